/* design/threshold_event_queue_core_macros.svh */
// ----------------------------------------------------------------------------
// threshold event queue assertion macros
// shared concurrent assertion forms for the event queue core
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_EVENT_QUEUE_CORE_MACROS_SVH
`define THRESHOLD_EVENT_QUEUE_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define TEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define TEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/teq_pkg.sv */
// ----------------------------------------------------------------------------
// threshold event queue package
// widths, codes and the queue entry type shared by the core and its channels
// ----------------------------------------------------------------------------
package teq_pkg;

   // default sizing
   localparam int QUEUE_DEPTH_DEFAULT   = 64;
   localparam int CHANNEL_COUNT_DEFAULT = 4;
   localparam int FILL_W_DEFAULT        = $clog2(QUEUE_DEPTH_DEFAULT + 1);

   // field widths
   localparam int CMD_W      = 2;
   localparam int CHAN_W     = 2;
   localparam int VALUE_W    = 24;
   localparam int TIME_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int STAT_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int MASK_W     = 4;
   localparam int STAT_COUNT = 4;

   // commands
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STATS  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_POPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE_MASK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_STATS    = 3'd5;

   // statistic counter slots
   localparam int STAT_GENERATED = 0;
   localparam int STAT_PROCESSED = 1;
   localparam int STAT_OVERFLOWS = 2;
   localparam int STAT_VIOLATION = 3;

   // one queued event
   typedef struct packed {
      logic [CHAN_W-1:0]  chan;
      logic [VALUE_W-1:0] value;
      logic [TIME_W-1:0]  stamp;
   } event_entry_type;

endpackage

/* design/teq_channels.sv */
// ----------------------------------------------------------------------------
// threshold event queue channels
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------

// request channel: one command word
interface teq_req_if import teq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [CHAN_W-1:0]   channel;
   logic [VALUE_W-1:0]  sample;
   logic [TIME_W-1:0]   timestamp;

   modport source (output valid, command, channel, sample, timestamp, input ready);
   modport sink   (input valid, command, channel, sample, timestamp, output ready);
endinterface

// response channel: one result word
interface teq_rsp_if import teq_pkg::*; #(parameter int FILL_W = FILL_W_DEFAULT) ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CHAN_W-1:0]   event_channel;
   logic [VALUE_W-1:0]  event_value;
   logic [TIME_W-1:0]   event_time;
   logic [FILL_W-1:0]   fill_level;
   logic [STAT_W-1:0]   stat_value;

   modport source (output valid, status, event_channel, event_value, event_time,
                   fill_level, stat_value, input ready);
   modport sink   (input valid, status, event_channel, event_value, event_time,
                   fill_level, stat_value, output ready);
endinterface

// register write channel
interface teq_csr_if import teq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/threshold_event_queue_core.sv */
// ----------------------------------------------------------------------------
// threshold event queue core
// latency: the result word is valid the cycle after its request word is taken
// throughput: one word per cycle while the result side keeps up; a held result word stalls requests
// reset: synchronous; queue empties, counters clear, enable mask all ones
// ----------------------------------------------------------------------------
`include "threshold_event_queue_core_macros.svh"

module threshold_event_queue_core import teq_pkg::*; #(
   parameter  int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT,
   parameter  int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT,
   localparam int PTR_W         = $clog2(QUEUE_DEPTH),
   localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic clock,
   input  logic reset,
   teq_req_if.sink   req_chan,
   teq_rsp_if.source rsp_chan,
   teq_csr_if.sink   csr_chan
);

   // configuration registers
   logic [VALUE_W-1:0]  thr_ff [CHANNEL_COUNT];
   logic [MASK_W-1:0]   en_ff;
   logic                track_ff;

   // queue control and counters
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]   count_ff, count_in;
   logic [STAT_W-1:0]   cnt_ff [STAT_COUNT];
   logic [STAT_W-1:0]   cnt_in [STAT_COUNT];

   // event memory and read data
   event_entry_type     mem [QUEUE_DEPTH];
   event_entry_type     rd_data_ff;
   event_entry_type     wr_entry;

   // output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [STAT_W-1:0]   stat_value_ff, stat_value_in;

   // decode
   logic                req_fire, csr_fire;
   logic [VALUE_W-1:0]  thr_sel;
   logic                ch_on, hit, full, empty;
   logic                do_push, do_drop, do_pop;
   logic                popped;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   // threshold and enable of the addressed channel
   always_comb begin
      thr_sel = '0;
      ch_on   = 1'b0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (req_chan.channel == CHAN_W'(c)) begin
            thr_sel = thr_ff[c];
            ch_on   = en_ff[c];
         end
      end
   end

   assign hit     = ch_on && (req_chan.sample > thr_sel);
   assign full    = count_ff == FILL_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = req_fire && (req_chan.command == CMD_SAMPLE) && hit && !full;
   assign do_drop = req_fire && (req_chan.command == CMD_SAMPLE) && hit && full;
   assign do_pop  = req_fire && (req_chan.command == CMD_POP) && !empty;

   assign wr_entry.chan  = req_chan.channel;
   assign wr_entry.value = req_chan.sample;
   assign wr_entry.stamp = req_chan.timestamp;

   // result status and stats read
   always_comb begin
      status_in     = STATUS_OK;
      stat_value_in = '0;
      case (req_chan.command)
         CMD_SAMPLE: begin
            if (hit) begin
               status_in = full ? STATUS_OVERFLOW : STATUS_QUEUED;
            end
         end
         CMD_POP: begin
            status_in = empty ? STATUS_EMPTY : STATUS_POPPED;
         end
         CMD_STATS: begin
            stat_value_in = cnt_ff[req_chan.channel];
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // pointer and fill level update, wrapping at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   // statistic counters, advancing only while tracking
   always_comb begin
      for (int i = 0; i < STAT_COUNT; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (track_ff) begin
         if (do_push) begin
            cnt_in[STAT_GENERATED] = cnt_ff[STAT_GENERATED] + 1'b1;
         end
         if (do_pop) begin
            cnt_in[STAT_PROCESSED] = cnt_ff[STAT_PROCESSED] + 1'b1;
         end
         if (do_drop) begin
            cnt_in[STAT_OVERFLOWS] = cnt_ff[STAT_OVERFLOWS] + 1'b1;
         end
         if (do_push || do_drop) begin
            cnt_in[STAT_VIOLATION] = cnt_ff[STAT_VIOLATION] + 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STAT_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         for (int i = 0; i < STAT_COUNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            thr_ff[c] <= '0;
         end
         en_ff    <= '1;
         track_ff <= 1'b1;
      end else if (csr_fire) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (csr_chan.index == REG_THRESHOLD_BASE + CSR_IDX_W'(c)) begin
               thr_ff[c] <= csr_chan.data[VALUE_W-1:0];
            end
         end
         if (csr_chan.index == REG_ENABLE_MASK) begin
            en_ff <= csr_chan.data[MASK_W-1:0];
         end
         if (csr_chan.index == REG_TRACK_STATS) begin
            track_ff <= csr_chan.data[0];
         end
      end
   end

   // event memory: write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_entry;
      end
      if (do_pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff     <= status_in;
         fill_ff       <= count_in;
         stat_value_ff <= stat_value_in;
      end
   end

   // event fields show only on a successful pop
   assign popped                 = status_ff == STATUS_POPPED;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.fill_level    = fill_ff;
   assign rsp_chan.stat_value    = stat_value_ff;
   assign rsp_chan.event_channel = popped ? rd_data_ff.chan  : '0;
   assign rsp_chan.event_value   = popped ? rd_data_ff.value : '0;
   assign rsp_chan.event_time    = popped ? rd_data_ff.stamp : '0;

   // checks
   `TEQ_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
      count_ff <= FILL_W'(QUEUE_DEPTH), "fill level beyond queue depth")
   `TEQ_ASSERT_NOW(a_empty_ptrs, clock, reset, count_ff == '0,
      rd_ptr_ff == wr_ptr_ff, "empty queue with pointers apart")
   `TEQ_ASSERT_NEXT(a_pop_empty, clock, reset,
      req_fire && (req_chan.command == CMD_POP) && empty,
      (status_ff == STATUS_EMPTY) && (count_ff == '0), "pop on empty queue changed state")
   `TEQ_ASSERT_NEXT(a_full_drop, clock, reset, do_drop,
      (status_ff == STATUS_OVERFLOW) && (count_ff == FILL_W'(QUEUE_DEPTH)),
      "drop on full queue changed fill level")

endmodule
